// ===== src/lpsd_pkg.sv =====
package lpsd_pkg;

    localparam int LEN_BITS = 16;
    localparam int MAX_LEN_W = 16;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam int HDR_CNT_W = 3;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 16'd4086;
    localparam logic [HDR_CNT_W-1:0] HDR_LAST = 3'd7;

    // register byte addresses
    localparam logic [ADDR_W-1:0] REG_MAX_LEN = 3'd0;

    typedef logic [LEN_BITS-1:0] t_len;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [31:0] frame_type;
        logic [7:0]  payload_byte;
        logic        has_byte;
        logic        first_of_frame;
        logic        last_of_frame;
        logic        length_error;
    } t_result;

endpackage

// ===== src/lpsd_cfg.sv =====
module lpsd_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lpsd_pkg::ADDR_W-1:0]    paddr,
    input  logic [lpsd_pkg::DATA_W-1:0]    pwdata,
    output logic [lpsd_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output logic [lpsd_pkg::MAX_LEN_W-1:0] o_max_len
);

    logic [lpsd_pkg::MAX_LEN_W-1:0] r_max_len;
    logic                           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == lpsd_pkg::REG_MAX_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= lpsd_pkg::MAX_LEN_RESET;
        end else if (wr_en) begin
            r_max_len <= pwdata[lpsd_pkg::MAX_LEN_W-1:0];
        end
    end

    always_comb begin
        unique case (paddr)
            lpsd_pkg::REG_MAX_LEN: begin
                prdata = lpsd_pkg::DATA_W'(r_max_len);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_max_len = r_max_len;

endmodule

// ===== src/lpsd_core.sv =====
module lpsd_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [7:0]                     i_data_byte,
    input  logic [lpsd_pkg::MAX_LEN_W-1:0] i_max_len,
    output logic                           o_res_valid,
    output lpsd_pkg::t_result              o_res
);

    lpsd_pkg::t_phase                r_phase, n_phase;
    logic [lpsd_pkg::HDR_CNT_W-1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [31:0]                     r_type, n_type;
    logic [23:0]                     r_len_lo, n_len_lo;
    lpsd_pkg::t_len                  r_bytes_left, n_bytes_left;
    logic                            r_first, n_first;

    logic [31:0] full_len;
    logic        hdr_done;
    logic        len_err;
    logic        len_zero;
    logic        pay_last;

    // top length byte arrives with the last header byte
    assign full_len = {i_data_byte, r_len_lo};
    assign hdr_done = (r_hdr_cnt == lpsd_pkg::HDR_LAST);
    assign len_err  = (full_len > 32'(i_max_len)) || (|full_len[31:lpsd_pkg::LEN_BITS]);
    assign len_zero = (full_len == 32'd0);
    assign pay_last = (r_bytes_left <= lpsd_pkg::t_len'(1));

    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            unique case (r_phase)
                lpsd_pkg::PH_HEADER: begin
                    if (hdr_done) begin
                        if (len_err) begin
                            n_phase = lpsd_pkg::PH_ERROR;
                        end else if (!len_zero) begin
                            n_phase = lpsd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                lpsd_pkg::PH_PAYLOAD: begin
                    if (pay_last) begin
                        n_phase = lpsd_pkg::PH_HEADER;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_comb begin
        n_hdr_cnt    = r_hdr_cnt;
        n_type       = r_type;
        n_len_lo     = r_len_lo;
        n_bytes_left = r_bytes_left;
        n_first      = r_first;
        o_res_valid  = 1'b0;
        o_res        = '0;
        o_res.frame_type = r_type;
        if (i_accept) begin
            unique case (r_phase)
                lpsd_pkg::PH_HEADER: begin
                    n_hdr_cnt = r_hdr_cnt + lpsd_pkg::HDR_CNT_W'(1);
                    for (int i = 0; i < 4; i++) begin
                        if (!r_hdr_cnt[2] && (r_hdr_cnt[1:0] == 2'(i))) begin
                            n_type[8*i +: 8] = i_data_byte;
                        end
                    end
                    for (int i = 0; i < 3; i++) begin
                        if (r_hdr_cnt[2] && (r_hdr_cnt[1:0] == 2'(i))) begin
                            n_len_lo[8*i +: 8] = i_data_byte;
                        end
                    end
                    if (hdr_done) begin
                        n_first = 1'b1;
                        if (len_err) begin
                            o_res_valid        = 1'b1;
                            o_res.length_error = 1'b1;
                        end else if (len_zero) begin
                            o_res_valid          = 1'b1;
                            o_res.first_of_frame = 1'b1;
                            o_res.last_of_frame  = 1'b1;
                        end else begin
                            n_bytes_left = full_len[lpsd_pkg::LEN_BITS-1:0];
                        end
                    end
                end
                lpsd_pkg::PH_PAYLOAD: begin
                    o_res_valid          = 1'b1;
                    o_res.payload_byte   = i_data_byte;
                    o_res.has_byte       = 1'b1;
                    o_res.first_of_frame = r_first;
                    o_res.last_of_frame  = pay_last;
                    if (pay_last) begin
                        n_bytes_left = '0;
                        n_first      = 1'b1;
                    end else begin
                        n_bytes_left = r_bytes_left - lpsd_pkg::t_len'(1);
                        n_first      = 1'b0;
                    end
                end
                default: begin
                    // halted: drop the item
                    o_res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lpsd_pkg::PH_HEADER;
            r_hdr_cnt    <= '0;
            r_type       <= '0;
            r_len_lo     <= '0;
            r_bytes_left <= '0;
            r_first      <= 1'b1;
        end else begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_type       <= n_type;
            r_len_lo     <= n_len_lo;
            r_bytes_left <= n_bytes_left;
            r_first      <= n_first;
        end
    end

endmodule

// ===== src/lpsd_obuf.sv =====
module lpsd_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpsd_pkg::t_result i_res,
    output logic              o_can_push,
    output logic              o_valid,
    input  logic              i_ready,
    output lpsd_pkg::t_result o_res
);

    logic              r_main_valid;
    logic              r_skid_valid;
    lpsd_pkg::t_result r_main;
    lpsd_pkg::t_result r_skid;
    logic              pop;

    assign pop        = r_main_valid && i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_res      = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (r_main_valid && !pop) begin
                r_skid <= i_res;
            end else begin
                r_main <= i_res;
            end
        end
    end

endmodule

// ===== src/length_prefixed_stream_deframer_top.sv =====
// Throughput: one byte per cycle while o_ready is high. Header bytes produce no result,
// but the last one on a length error or zero length; halted-state bytes produce none.
// A two-entry output buffer holds a second result while i_ready is low; the input
// stalls once both entries are full and resumes the cycle after one is taken.
// Reset: synchronous, active low; clears the parser to the header phase and sets
// max_payload_len to 4086.
module length_prefixed_stream_deframer_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [7:0]                           i_data_byte,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [31:0]                          o_frame_type,
    output logic [7:0]                           o_payload_byte,
    output logic                                 o_has_byte,
    output logic                                 o_first_of_frame,
    output logic                                 o_last_of_frame,
    output logic                                 o_length_error,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lpsd_pkg::ADDR_W-1:0]          paddr,
    input  logic [lpsd_pkg::DATA_W-1:0]          pwdata,
    output logic [lpsd_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    logic [lpsd_pkg::MAX_LEN_W-1:0] max_len;
    logic                           accept;
    logic                           res_valid;
    logic                           can_push;
    lpsd_pkg::t_result              core_res;
    lpsd_pkg::t_result              out_res;

    assign o_ready = can_push;
    assign accept  = i_valid && can_push;

    lpsd_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_max_len (max_len)
    );

    lpsd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_max_len   (max_len),
        .o_res_valid (res_valid),
        .o_res       (core_res)
    );

    lpsd_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_res      (core_res),
        .o_can_push (can_push),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    assign o_frame_type     = out_res.frame_type;
    assign o_payload_byte   = out_res.payload_byte;
    assign o_has_byte       = out_res.has_byte;
    assign o_first_of_frame = out_res.first_of_frame;
    assign o_last_of_frame  = out_res.last_of_frame;
    assign o_length_error   = out_res.length_error;

`ifndef SYNTH
    // input may stall only while a result is waiting
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no pending result");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_length_error) |->
            (!o_has_byte && !o_first_of_frame && !o_last_of_frame && o_payload_byte == 8'd0))
        else $error("malformed length error result");

    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_byte && !o_length_error) |->
            (o_first_of_frame && o_last_of_frame))
        else $error("empty result is not a whole frame");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_payload_byte != 8'd0)) |-> o_has_byte)
        else $error("payload byte set without has_byte");
`endif

endmodule
